// ===== rtl/lscd_pkg.sv =====
`timescale 1ns / 1ps
package lscd_pkg;

  localparam int SLOTS      = 256;
  localparam int AGE_LIMIT  = 4096;

  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int AGE_W      = $clog2(AGE_LIMIT + 1);
  localparam int DEV_W      = 4;
  localparam int SEC_W      = 16;
  localparam int SLOT_OUT_W = 8;

  // fills above this sector are declined in low-sector mode
  localparam logic [SEC_W-1:0] HALF_SEC = SEC_W'(SLOTS >> 1);

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_FILL   = 2'd2,
    CMD_INVAL  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              tag_we;
    logic              age_we;
    logic [SLOT_W-1:0] wr_addr;
    logic [DEV_W-1:0]  wr_dev;
    logic [SEC_W-1:0]  wr_sec;
    logic [AGE_W-1:0]  wr_age;
  } mem_req_t;

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [SEC_W-1:0] sec;
    logic [AGE_W-1:0] age;
  } mem_rsp_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  stored;
  } res_t;

  // low bits of a slot index, zero-extended when there are fewer
  function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_W-1:0] idx);
    logic [SLOT_OUT_W+SLOT_W-1:0] tmp;
    tmp = {{SLOT_OUT_W{1'b0}}, idx};
    return tmp[SLOT_OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/lscd_mem.sv =====
`timescale 1ns / 1ps
module lscd_mem
  import lscd_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [DEV_W+SEC_W-1:0] tag_mem [SLOTS];
  logic [AGE_W-1:0]       age_mem [SLOTS];

  // tag store: device and sector per slot; age store beside it
  always_ff @(posedge clk) begin
    if (req.tag_we) begin
      tag_mem[req.wr_addr] <= {req.wr_dev, req.wr_sec};
    end
    if (req.age_we) begin
      age_mem[req.wr_addr] <= req.wr_age;
    end
    if (req.rd_en) begin
      {rsp.dev, rsp.sec} <= tag_mem[req.rd_addr];
      rsp.age            <= age_mem[req.rd_addr];
    end
  end

endmodule

// ===== rtl/lscd_ctrl.sv =====
`timescale 1ns / 1ps
module lscd_ctrl
  import lscd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cmd_t             cmd,
  input  logic [DEV_W-1:0] dev,
  input  logic [SEC_W-1:0] sec,
  input  logic             low_only,
  input  logic             out_free,
  output logic             idle,
  output logic             res_valid,
  output res_t             res,
  output mem_req_t         req,
  input  mem_rsp_t         rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_AGE,
    S_DONE
  } state_t;

  localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [AGE_W-1:0]  AGE_MAX   = AGE_W'(AGE_LIMIT);

  state_t            state;
  cmd_t              cmd_q;
  logic [DEV_W-1:0]  dev_q;
  logic [SEC_W-1:0]  sec_q;
  logic [SLOTS-1:0]  slot_valid;
  logic [CNT_W-1:0]  cnt;
  logic              rd_pend;
  logic [SLOT_W-1:0] rd_idx;
  logic              rd_vbit;
  logic              match_found;
  logic [SLOT_W-1:0] match_idx;
  logic              inv_found;
  logic [SLOT_W-1:0] inv_idx;
  logic [AGE_W-1:0]  best_age;
  logic [SLOT_W-1:0] best_idx;

  logic              issue;
  logic              tag_eq;
  logic [SLOT_W-1:0] tgt;
  logic [AGE_W-1:0]  aged;

  assign issue  = ((state == S_SCAN) || (state == S_AGE)) && (cnt < SLOTS_CNT);
  assign tag_eq = (rsp.dev == dev_q) && (rsp.sec == sec_q);
  assign tgt    = match_found ? match_idx : (inv_found ? inv_idx : best_idx);
  assign aged   = (rsp.age < AGE_MAX) ? rsp.age + AGE_W'(1) : rsp.age;

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    req         = '0;
    req.rd_en   = issue;
    req.rd_addr = cnt[SLOT_W-1:0];
    if ((state == S_DECIDE) && (cmd_q != CMD_LOOKUP)) begin
      req.age_we  = 1'b1;
      req.tag_we  = !match_found;
      req.wr_addr = tgt;
      req.wr_dev  = dev_q;
      req.wr_sec  = sec_q;
      req.wr_age  = '0;
    end else if ((state == S_AGE) && rd_pend) begin
      req.age_we  = 1'b1;
      req.wr_addr = rd_idx;
      req.wr_age  = aged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pend    <= 1'b0;
      slot_valid <= '0;
    end else begin
      // read issue, shared by scan and ageing passes
      if (issue) begin
        cnt     <= cnt + CNT_W'(1);
        rd_idx  <= cnt[SLOT_W-1:0];
        rd_vbit <= slot_valid[cnt[SLOT_W-1:0]];
      end
      rd_pend <= issue;

      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q       <= cmd;
            dev_q       <= dev;
            sec_q       <= sec;
            cnt         <= '0;
            match_found <= 1'b0;
            match_idx   <= '0;
            inv_found   <= 1'b0;
            inv_idx     <= '0;
            best_age    <= '0;
            best_idx    <= '0;
            res         <= '0;
            if (cmd == CMD_INVAL) begin
              slot_valid <= '0;
              state      <= S_DONE;
            end else if ((cmd == CMD_FILL) && low_only && (sec > HALF_SEC)) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_pend) begin
            if (rd_vbit && tag_eq && !match_found) begin
              match_found <= 1'b1;
              match_idx   <= rd_idx;
            end
            if (!rd_vbit && !inv_found) begin
              inv_found <= 1'b1;
              inv_idx   <= rd_idx;
            end
            if (rd_vbit && (rsp.age >= best_age)) begin
              best_age <= rsp.age;
              best_idx <= rd_idx;
            end
            if (rd_idx == LAST_SLOT) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          cnt <= '0;
          if (cmd_q == CMD_LOOKUP) begin
            res.hit    <= match_found;
            res.stored <= match_found;
            res.slot   <= match_found ? slot_out(match_idx) : '0;
            state      <= S_DONE;
          end else begin
            slot_valid[tgt] <= 1'b1;
            res.hit         <= match_found;
            res.stored      <= 1'b1;
            res.slot        <= slot_out(tgt);
            if ((cmd_q == CMD_FILL) || !match_found) begin
              state <= S_AGE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_AGE: begin
          if (rd_pend && (rd_idx == LAST_SLOT)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a read is in flight only during one of the two passes
  a_pend_in_pass: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> ((state == S_SCAN) || (state == S_AGE)))
    else $error("read data pending outside a pass");

  // the scan never writes the stores
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (!req.tag_we && !req.age_we))
    else $error("store written during scan");

  // an allocated or refreshed slot is valid afterwards
  a_tgt_valid: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DECIDE) && (cmd_q != CMD_LOOKUP)) |=> slot_valid[$past(tgt)])
    else $error("target slot not marked valid");

  // ageing writes back the entry read in the cycle before
  a_age_trail: assert property (@(posedge clk) disable iff (rst)
    ((state == S_AGE) && req.age_we) |-> (req.wr_addr == $past(req.rd_addr)))
    else $error("ageing write address out of step");

  // a result that stores nothing reports no hit and slot zero
  a_res_empty: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && !res.stored) |-> (!res.hit && (res.slot == '0)))
    else $error("empty result carries a slot or hit");

endmodule

// ===== rtl/lru_sector_cache_directory.sv =====
`timescale 1ns / 1ps
// sequence: lookup and write hit run the match scan only; write miss and fill add the ageing pass;
//   invalidate and a declined fill go straight from item accept to the result in the output register
// throughput: one item at a time; the tag/age memory read port sets the pace, one slot a cycle
//   for the match scan and again for the ageing pass
// reset: synchronous, clears every slot valid bit, the mode register and the handshake state;
//   tag and age memories are not cleared, so an item can be taken in the first cycle after reset
module lru_sector_cache_directory
  import lscd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // config register
  input  logic                  cfg_write,
  input  logic                  cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            command,
  input  logic [DEV_W-1:0]      device,
  input  logic [SEC_W-1:0]      sector,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  hit,
  output logic [SLOT_OUT_W-1:0] slot,
  output logic                  stored
);

  logic     low_sectors_only;
  logic     start;
  logic     idle;
  logic     res_valid;
  logic     out_free;
  res_t     res;
  mem_req_t req;
  mem_rsp_t rsp;

  // mode register: decline fills of high sectors
  always_ff @(posedge clk) begin
    if (rst) begin
      low_sectors_only <= 1'b0;
    end else if (cfg_write) begin
      low_sectors_only <= cfg_data;
    end
  end

  // a new item is taken whenever the sequencer is idle, even while a result waits below
  assign in_stall = !idle;
  assign start    = in_valid && !in_stall;

  // the output register frees when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  // sequencer: match scan, victim pick, tag/age update and ageing pass
  lscd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd_t'(command)),
    .dev       (device),
    .sec       (sector),
    .low_only  (low_sectors_only),
    .out_free  (out_free),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res),
    .req       (req),
    .rsp       (rsp)
  );

  // tag and age stores, registered read
  lscd_mem u_mem (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  // result register parting the sequencer from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_valid && out_free) begin
        out_valid <= 1'b1;
        hit       <= res.hit;
        slot      <= res.slot;
        stored    <= res.stored;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== dv/lru_sector_cache_directory_tb.sv =====
`timescale 1ns / 1ps
module lru_sector_cache_directory_tb;
  import lscd_pkg::*;

  // one command item as the sender presents it
  typedef struct {
    cmd_t             op;
    logic [DEV_W-1:0] dev;
    logic [SEC_W-1:0] sec;
  } dir_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_write = 1'b0;
  logic                  cfg_data  = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [1:0]            command   = 2'b00;
  logic [DEV_W-1:0]      device    = '0;
  logic [SEC_W-1:0]      sector    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  stored;

  // items waiting to be sent, and the replies the directory owes us
  dir_item_t command_q[$];
  res_t      reply_q[$];
  bit        failed = 1'b0;

  // shadow directory
  bit               dir_valid[SLOTS];
  logic [DEV_W-1:0] dir_dev[SLOTS];
  logic [SEC_W-1:0] dir_sec[SLOTS];
  int unsigned      dir_age[SLOTS];
  bit               low_mode = 1'b0;

  // recent out-of-range keys, revisited now and then so that wide tags can hit
  logic [DEV_W+SEC_W-1:0] recent_keys[$];

  // a long window in which neither side idles
  int unsigned cycle_no = 0;
  wire         calm = (cycle_no >= 100000) && (cycle_no < 200000);

  lru_sector_cache_directory i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .device    (device),
    .sector    (sector),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .slot      (slot),
    .stored    (stored)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // directory behaviour for one command: updates the shadow state, returns the reply
  function automatic res_t directory_step(cmd_t op, logic [DEV_W-1:0] dev,
                                          logic [SEC_W-1:0] sec);
    res_t        r;
    int          m;
    int          s;
    int          i;
    int unsigned oldest;
    r = '0;
    m = -1;
    s = 0;
    if (op == CMD_INVAL) begin
      foreach (dir_valid[j]) dir_valid[j] = 1'b0;
      return r;
    end
    // declined fill: nothing looked up, nothing changes
    if (op == CMD_FILL && low_mode && sec > HALF_SEC) return r;
    // lowest matching valid slot wins
    for (i = 0; i < SLOTS; i++) begin
      if (m < 0 && dir_valid[i] && dir_dev[i] == dev && dir_sec[i] == sec) m = i;
    end
    if (op == CMD_LOOKUP) begin
      if (m >= 0) begin
        r.hit    = 1'b1;
        r.stored = 1'b1;
        r.slot   = SLOT_OUT_W'(m);
      end
      return r;
    end
    if (m >= 0) begin
      r.hit      = 1'b1;
      s          = m;
      dir_age[s] = 0;
    end else begin
      // first free slot, else the oldest, highest index on a tie
      s      = -1;
      oldest = 0;
      for (i = 0; i < SLOTS && s < 0; i++) begin
        if (!dir_valid[i]) s = i;
      end
      if (s < 0) begin
        for (i = 0; i < SLOTS; i++) begin
          if (dir_age[i] >= oldest) begin
            oldest = dir_age[i];
            s      = i;
          end
        end
      end
      dir_valid[s] = 1'b1;
      dir_dev[s]   = dev;
      dir_sec[s]   = sec;
      dir_age[s]   = 0;
    end
    // a write hit only refreshes; every other case ages the lot
    if (op == CMD_FILL || m < 0) begin
      for (i = 0; i < SLOTS; i++) begin
        if (dir_age[i] < AGE_LIMIT) dir_age[i] = dir_age[i] + 1;
      end
    end
    r.slot   = SLOT_OUT_W'(s);
    r.stored = 1'b1;
    return r;
  endfunction

  // sender: next item only once the current one has gone, with random gaps
  always @(posedge clk) begin : drive
    dir_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) reply_q.push_back(directory_step(cmd_t'(command), device, sector));
      if (command_q.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
        nxt      = command_q.pop_front();
        command  <= nxt.op;
        device   <= nxt.dev;
        sector   <= nxt.sec;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls at random outside the calm window
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 8);
  end

  task automatic check_field(string name, logic [SLOT_OUT_W-1:0] want,
                             logic [SLOT_OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        $display("%0t: reply with nothing outstanding, expected none, actual hit %0d slot %0d",
                 $time, hit, slot);
        failed = 1'b1;
      end else begin
        want = reply_q.pop_front();
        check_field("hit", SLOT_OUT_W'(want.hit), SLOT_OUT_W'(hit));
        check_field("slot", want.slot, slot);
        check_field("stored", SLOT_OUT_W'(want.stored), SLOT_OUT_W'(stored));
      end
    end
  end

  task automatic queue_item(cmd_t op, logic [DEV_W-1:0] dev, logic [SEC_W-1:0] sec);
    dir_item_t it;
    it.op  = op;
    it.dev = dev;
    it.sec = sec;
    command_q.push_back(it);
  endtask

  // mostly a hot set that straddles the low-sector threshold, so hits, evictions
  // and declined fills all turn up; the rest is the whole key space
  task automatic queue_random(int count, bit with_inval);
    int                     r;
    int                     k;
    cmd_t                   op;
    logic [DEV_W-1:0]       dev;
    logic [SEC_W-1:0]       sec;
    logic [DEV_W+SEC_W-1:0] key;
    repeat (count) begin
      r = $urandom_range(99);
      if (with_inval && r < 2)  op = CMD_INVAL;
      else if (r < 30)          op = CMD_LOOKUP;
      else if (r < 62)          op = CMD_WRITE;
      else                      op = CMD_FILL;
      k = $urandom_range(99);
      if (k < 65) begin
        dev = DEV_W'($urandom_range(7));
        sec = SEC_W'(112 + $urandom_range(39));
      end else if (k < 75 && recent_keys.size() != 0) begin
        key = recent_keys[$urandom_range(recent_keys.size() - 1)];
        {dev, sec} = key;
      end else begin
        dev = DEV_W'($urandom);
        sec = SEC_W'($urandom);
        recent_keys.push_back({dev, sec});
        if (recent_keys.size() > 16) void'(recent_keys.pop_front());
      end
      queue_item(op, dev, sec);
    end
  endtask

  // hold the sender until the directory has answered everything
  task automatic drain;
    do @(negedge clk);
    while (command_q.size() != 0 || in_valid || reply_q.size() != 0);
  endtask

  // mode register, written only while the directory is idle
  task automatic set_low_mode(bit v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    low_mode  = v;
    @(negedge clk);
  endtask

  initial begin
    foreach (dir_valid[j]) begin
      dir_valid[j] = 1'b0;
      dir_dev[j]   = '0;
      dir_sec[j]   = '0;
      dir_age[j]   = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_low_mode(1'b0);

    // empty directory, extreme tags, hits and refreshes
    queue_item(CMD_LOOKUP, 4'd0, 16'h0000);
    queue_item(CMD_WRITE, 4'd15, 16'hffff);
    queue_item(CMD_WRITE, 4'd0, 16'h0000);
    queue_item(CMD_LOOKUP, 4'd15, 16'hffff);
    queue_item(CMD_WRITE, 4'd15, 16'hffff);
    queue_item(CMD_FILL, 4'd0, 16'h0000);
    queue_item(CMD_FILL, 4'd3, 16'h1234);
    queue_item(CMD_LOOKUP, 4'd3, 16'h1234);
    // near misses on device and on sector
    queue_item(CMD_LOOKUP, 4'd14, 16'hffff);
    queue_item(CMD_LOOKUP, 4'd15, 16'hfffe);
    // two write hits in a row leave two slots at the same age
    queue_item(CMD_WRITE, 4'd15, 16'hffff);
    queue_item(CMD_WRITE, 4'd3, 16'h1234);
    queue_item(CMD_WRITE, 4'd8, 16'h8000);
    // invalidate, then stale tags must not match and slot 0 is reused
    queue_item(CMD_INVAL, 4'd9, 16'h5a5a);
    queue_item(CMD_LOOKUP, 4'd15, 16'hffff);
    queue_item(CMD_FILL, 4'd7, 16'h00ff);
    queue_item(CMD_WRITE, 4'd7, 16'h00ff);
    drain();

    // low-sector mode: fills either side of the threshold, writes unaffected
    set_low_mode(1'b1);
    queue_item(CMD_FILL, 4'd1, HALF_SEC + 16'd1);
    queue_item(CMD_FILL, 4'd1, HALF_SEC);
    queue_item(CMD_FILL, 4'd1, 16'hffff);
    queue_item(CMD_WRITE, 4'd1, 16'hffff);
    queue_item(CMD_LOOKUP, 4'd1, HALF_SEC + 16'd1);
    queue_item(CMD_LOOKUP, 4'd1, HALF_SEC);
    queue_random(200, 1'b1);
    drain();

    // long run without invalidates so the directory fills and starts evicting
    set_low_mode(1'b0);
    queue_random(500, 1'b0);
    drain();

    set_low_mode(1'b1);
    queue_random(100, 1'b1);
    drain();

    // allow for a stray late reply
    repeat (2 * SLOTS + 8) @(posedge clk);
    if (!failed && reply_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lscd_pkg.sv
rtl/lscd_mem.sv
rtl/lscd_ctrl.sv
rtl/lru_sector_cache_directory.sv
dv/lru_sector_cache_directory_tb.sv
